FILE: src/mmm_pkg.sv
// Package for the multirotor motor mixer: fixed-point widths, constants,
// coefficient types and configuration register indexes. No dependencies.
package mmm_pkg;

    localparam int ROW_COUNT   = 4;           // motor output ports
    localparam int MW          = 24;          // signed width of a mix value, Q.16
    localparam int SW          = 23;          // unsigned width of a mix spread
    localparam int TW          = 17;          // unsigned normalized throttle, 0..1.0
    localparam int QT          = 16;          // quotient bits of the throttle divide
    localparam int QS          = 22;          // quotient bits of the spread divide

    localparam logic [TW-1:0] ONE_Q16      = 17'd65536;
    localparam logic [28:0]   AXIS_RECIP   = 29'd274877907;  // ceil(2^38 / 1000)
    localparam int            AXIS_SHIFT   = 22;             // 38 - 16
    localparam logic [10:0]   DSHOT_LOW    = 11'd48;
    localparam logic [10:0]   DSHOT_STEPS  = 11'd1999;

    typedef logic signed [MW-1:0] mix_t;
    typedef logic signed [7:0]    coef_t;

    typedef enum logic [2:0] {
        CFG_THR_MIN  = 3'd0,
        CFG_THR_SPAN = 3'd1,
        CFG_ROW0     = 3'd2,
        CFG_ROW1     = 3'd3,
        CFG_ROW2     = 3'd4,
        CFG_ROW3     = 3'd5
    } cfg_idx_t;

    // Coefficient k of a mix row: 0 throttle, 1 roll, 2 pitch, 3 yaw.
    function automatic coef_t coef_of(input logic [31:0] row, input int k);
        return coef_t'(row[8*k +: 8]);
    endfunction

endpackage

FILE: src/mmm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Self-contained; used by the motor mixer top level.
module mmm_div #(
    parameter int DW = 23,
    parameter int QW = 22
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] low_next [QW];
    logic [DW-1:0] den_next [QW];
    logic [QW-1:0] quo_next [QW];

    always_comb
    begin
        logic [DW:0]   trial;
        logic [DW-1:0] r_src;
        logic [DW-1:0] d_src;
        logic [QW-1:0] l_src;
        logic [QW-1:0] q_src;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                r_src = rem_in;
                d_src = den_in;
                l_src = low_in;
                q_src = '0;
            end
            else
            begin
                r_src = rem_reg[k-1];
                d_src = den_reg[k-1];
                l_src = low_reg[k-1];
                q_src = quo_reg[k-1];
            end
            trial = {r_src, l_src[QW-1]};
            // subtract when the trial remainder covers the divisor
            if (trial >= {1'b0, d_src})
            begin
                rem_next[k] = DW'(trial - {1'b0, d_src});
                quo_next[k] = {q_src[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DW-1:0];
                quo_next[k] = {q_src[QW-2:0], 1'b0};
            end
            low_next[k] = {l_src[QW-2:0], 1'b0};
            den_next[k] = d_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

FILE: src/multirotor_motor_mixer.sv
// Multirotor motor mixer top level: fully pipelined quad-X mixer.
// Depends on mmm_pkg and mmm_div.

// Quad-X motor mixer. Each command transaction carries a PWM-unit throttle,
// three PID axis sums and an armed flag, and yields one result transaction of
// four DShot motor values (48..2047) and the constrained throttle as unsigned
// Q0.16. The block takes one command every clock cycle while cmd_stall is low
// and returns results in order; most of its pipeline is the 22-stage divider
// that rescales the mixes when their spread exceeds 1.0 (one quotient bit per
// stage), with the throttle normalization running through its own 16-stage
// divider in parallel. The whole pipeline advances together: while a result
// is held by mix_stall, every stage holds and cmd_stall is raised, so nothing
// is lost or repeated. Valid bits travel with the data. Disarmed commands give
// 48 on every motor and zero throttle. Only the first MOTORS rows (at most
// four) are mixed; the other motor ports read 48. Write the configuration
// registers (throttle range and the four coefficient rows, signed Q1.6 bytes)
// only while the pipeline is empty; cfg_ready is always high and writes to
// unknown indexes are dropped.
module multirotor_motor_mixer
    import mmm_pkg::*;
#(
    parameter int MOTORS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [11:0]         throttle_cmd,
    input  logic signed [12:0]  axis_roll,
    input  logic signed [12:0]  axis_pitch,
    input  logic signed [12:0]  axis_yaw,
    input  logic                is_armed,
    // result channel
    output logic                mix_valid,
    input  logic                mix_stall,
    output logic [10:0]         motor_0,
    output logic [10:0]         motor_1,
    output logic [10:0]         motor_2,
    output logic [10:0]         motor_3,
    output logic [15:0]         throttle_applied,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int NMIX  = (MOTORS < 1) ? 1 : ((MOTORS > ROW_COUNT) ? ROW_COUNT : MOTORS);
    localparam int LAT   = 6 + QS + 5;     // total register stages
    localparam int TDLY  = 6 + QS - 1 - QT; // throttle wait after its divider
    localparam int ADLY  = LAT - 2;         // armed flag delay after stage 1

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0] thr_min_reg;
    logic [11:0] thr_span_reg;
    logic [31:0] row_reg [ROW_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_min_reg  <= 12'd1000;
            thr_span_reg <= 12'd1000;
            row_reg[0]   <= 32'd3225468992;
            row_reg[1]   <= 32'd1086373952;
            row_reg[2]   <= 32'd1077952576;
            row_reg[3]   <= 32'd3233824832;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_THR_MIN:  thr_min_reg  <= cfg_data[11:0];
                CFG_THR_SPAN: thr_span_reg <= cfg_data[11:0];
                CFG_ROW0:     row_reg[0]   <= cfg_data;
                CFG_ROW1:     row_reg[1]   <= cfg_data;
                CFG_ROW2:     row_reg[2]   <= cfg_data;
                CFG_ROW3:     row_reg[3]   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: advance all stages unless the result is held
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en        = !(vld_reg[LAT-1] && mix_stall);
    assign cmd_stall = !en;
    assign mix_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], cmd_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: throttle offset and range flags, axis magnitudes
    // ------------------------------------------------------------------
    logic [11:0] s1_d_reg;
    logic [11:0] s1_span_reg;
    logic        s1_zero_reg;
    logic        s1_one_reg;
    logic [12:0] s1_abs_reg [3];
    logic        s1_neg_reg [3];
    logic        s1_arm_reg;
    logic [11:0] d_next;
    logic [11:0] span_next;
    logic signed [12:0] ax_in [3];

    assign ax_in[0] = axis_roll;
    assign ax_in[1] = axis_pitch;
    assign ax_in[2] = axis_yaw;

    always_comb
    begin
        d_next    = throttle_cmd - thr_min_reg;
        // a zero span acts as a span of one
        span_next = (thr_span_reg == 12'd0) ? 12'd1 : thr_span_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_d_reg    <= d_next;
            s1_span_reg <= span_next;
            s1_zero_reg <= (throttle_cmd <= thr_min_reg);
            s1_one_reg  <= (d_next >= span_next);
            s1_arm_reg  <= is_armed;
            for (int k = 0; k < 3; k++)
            begin
                s1_neg_reg[k] <= ax_in[k][12];
                s1_abs_reg[k] <= ax_in[k][12] ? (~ax_in[k] + 13'd1) : ax_in[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Throttle normalization: (cmd - min) * 65536 / span over 16 stages
    // ------------------------------------------------------------------
    logic [QT-1:0] thr_quo;
    logic [QT-1:0] thr_zero_dly_reg;
    logic [QT-1:0] thr_one_dly_reg;
    logic [TW-1:0] t_norm;
    logic [TW-1:0] t_dly_reg [TDLY];

    mmm_div #(
        .DW (12),
        .QW (QT)
    ) u_thr_div (
        .clk    (clk),
        .en     (en),
        .rem_in (s1_d_reg),
        .low_in ('0),
        .den_in (s1_span_reg),
        .quo    (thr_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            thr_zero_dly_reg <= {thr_zero_dly_reg[QT-2:0], s1_zero_reg};
            thr_one_dly_reg  <= {thr_one_dly_reg[QT-2:0], s1_one_reg};
        end
    end

    always_comb
    begin
        if (thr_zero_dly_reg[QT-1])
            t_norm = '0;
        else if (thr_one_dly_reg[QT-1])
            t_norm = ONE_Q16;
        else
            t_norm = {1'b0, thr_quo};
    end

    // hold the throttle until the scaled mixes catch up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_dly_reg[0] <= t_norm;
            for (int k = 1; k < TDLY; k++)
                t_dly_reg[k] <= t_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Armed flag rides alongside to the output stage
    // ------------------------------------------------------------------
    logic [ADLY-1:0] arm_dly_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            arm_dly_reg <= {arm_dly_reg[ADLY-2:0], s1_arm_reg};
    end

    // ------------------------------------------------------------------
    // Stages 2-3: axis * 65536 / 1000 by reciprocal multiply, yaw negated
    // ------------------------------------------------------------------
    logic [41:0]        s2_prod_reg [3];
    logic               s2_neg_reg  [3];
    logic signed [19:0] s3_ax_reg   [3];
    logic signed [19:0] s3_ax_next  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_prod_reg[k] <= 42'(s1_abs_reg[k]) * 42'(AXIS_RECIP);
                s2_neg_reg[k]  <= s1_neg_reg[k];
            end
        end
    end

    always_comb
    begin
        logic [18:0] q;
        logic        neg_eff;
        for (int k = 0; k < 3; k++)
        begin
            q       = s2_prod_reg[k][AXIS_SHIFT+18:AXIS_SHIFT];
            // truncation toward zero, then flip yaw
            neg_eff = s2_neg_reg[k] ^ (k == 2);
            s3_ax_next[k] = neg_eff ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                s3_ax_reg[k] <= s3_ax_next[k];
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-5: per-motor dot product, then /64 toward zero
    // ------------------------------------------------------------------
    logic signed [29:0] s4_p_reg  [ROW_COUNT];
    logic signed [29:0] s4_p_next [ROW_COUNT];
    mix_t               s5_mix_reg  [ROW_COUNT];
    mix_t               s5_mix_next [ROW_COUNT];

    always_comb
    begin
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            s4_p_next[i] = 30'(s3_ax_reg[0]) * 30'(coef_of(row_reg[i], 1))
                         + 30'(s3_ax_reg[1]) * 30'(coef_of(row_reg[i], 2))
                         + 30'(s3_ax_reg[2]) * 30'(coef_of(row_reg[i], 3));
            s5_mix_next[i] = MW'((s4_p_reg[i] + ((s4_p_reg[i] < 0) ? 30'sd63 : 30'sd0)) >>> 6);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                s4_p_reg[i]   <= s4_p_next[i];
                s5_mix_reg[i] <= s5_mix_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: spread of the mixed motors
    // ------------------------------------------------------------------
    mix_t          s6_mix_reg [ROW_COUNT];
    logic [SW-1:0] s6_spread_reg;
    logic          s6_big_reg;
    logic [SW-1:0] spread_next;

    always_comb
    begin
        mix_t lo;
        mix_t hi;
        lo = s5_mix_reg[0];
        hi = s5_mix_reg[0];
        for (int i = 1; i < NMIX; i++)
        begin
            if (s5_mix_reg[i] > hi)
                hi = s5_mix_reg[i];
            if (s5_mix_reg[i] < lo)
                lo = s5_mix_reg[i];
        end
        spread_next = SW'(hi - lo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
                s6_mix_reg[i] <= s5_mix_reg[i];
            s6_spread_reg <= spread_next;
            s6_big_reg    <= (spread_next > SW'(ONE_Q16));
        end
    end

    // ------------------------------------------------------------------
    // Stages 7-28: |mix| * 65536 / spread, one divider per motor
    // ------------------------------------------------------------------
    logic [QS-1:0] mix_quo     [ROW_COUNT];
    mix_t          mix_dly_reg [QS][ROW_COUNT];
    logic [QS-1:0] big_dly_reg;

    for (genvar g = 0; g < ROW_COUNT; g++)
    begin : g_scale
        mix_t          mag;
        logic [SW-1:0] mag_u;

        assign mag   = (s6_mix_reg[g] < 0) ? -s6_mix_reg[g] : s6_mix_reg[g];
        assign mag_u = mag[SW-1:0];

        mmm_div #(
            .DW (SW),
            .QW (QS)
        ) u_mix_div (
            .clk    (clk),
            .en     (en),
            .rem_in (mag_u >> 6),
            .low_in ({mag_u[5:0], 16'd0}),
            .den_in (s6_spread_reg),
            .quo    (mix_quo[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_dly_reg <= {big_dly_reg[QS-2:0], s6_big_reg};
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                mix_dly_reg[0][i] <= s6_mix_reg[i];
                for (int k = 1; k < QS; k++)
                    mix_dly_reg[k][i] <= mix_dly_reg[k-1][i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 29: pick scaled or plain mixes, take their range again
    // ------------------------------------------------------------------
    mix_t          s29_mix_reg  [ROW_COUNT];
    mix_t          s29_mix_next [ROW_COUNT];
    mix_t          s29_lo_reg;
    mix_t          s29_hi_reg;
    mix_t          lo_next;
    mix_t          hi_next;
    logic [TW-1:0] s29_t_reg;

    always_comb
    begin
        mix_t q;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            q = $signed({2'b00, mix_quo[i]});
            if (big_dly_reg[QS-1])
                s29_mix_next[i] = (mix_dly_reg[QS-1][i] < 0) ? -q : q;
            else
                s29_mix_next[i] = mix_dly_reg[QS-1][i];
        end
        lo_next = s29_mix_next[0];
        hi_next = s29_mix_next[0];
        for (int i = 1; i < NMIX; i++)
        begin
            if (s29_mix_next[i] > hi_next)
                hi_next = s29_mix_next[i];
            if (s29_mix_next[i] < lo_next)
                lo_next = s29_mix_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
                s29_mix_reg[i] <= s29_mix_next[i];
            s29_lo_reg <= lo_next;
            s29_hi_reg <= hi_next;
            s29_t_reg  <= t_dly_reg[TDLY-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 30: hold throttle within [-min, 1 - max]
    // ------------------------------------------------------------------
    logic signed [MW:0] s30_t_reg;
    logic signed [MW:0] t_clamp_next;
    mix_t               s30_mix_reg [ROW_COUNT];

    always_comb
    begin
        logic signed [MW:0] lo_b;
        logic signed [MW:0] hi_b;
        logic signed [MW:0] t_s;
        lo_b = -(MW+1)'(s29_lo_reg);
        hi_b = $signed({{(MW+1-TW){1'b0}}, ONE_Q16}) - (MW+1)'(s29_hi_reg);
        t_s  = $signed({{(MW+1-TW){1'b0}}, s29_t_reg});
        if (t_s < lo_b)
            t_clamp_next = lo_b;
        else if (t_s > hi_b)
            t_clamp_next = hi_b;
        else
            t_clamp_next = t_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s30_t_reg <= t_clamp_next;
            for (int i = 0; i < ROW_COUNT; i++)
                s30_mix_reg[i] <= s29_mix_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 31: throttle times its coefficient
    // ------------------------------------------------------------------
    logic signed [MW+8:0] s31_prod_reg [ROW_COUNT];
    mix_t                 s31_mix_reg  [ROW_COUNT];
    logic signed [MW:0]   s31_t_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s31_t_reg <= s30_t_reg;
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                s31_prod_reg[i] <= (MW+9)'(s30_t_reg) * (MW+9)'(coef_of(row_reg[i], 0));
                s31_mix_reg[i]  <= s30_mix_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 32: mix + throttle share, clamped to 0..1
    // ------------------------------------------------------------------
    logic [TW-1:0] s32_o_reg  [ROW_COUNT];
    logic [TW-1:0] s32_o_next [ROW_COUNT];
    logic [15:0]   s32_thr_reg;
    logic [15:0]   thr_next;

    always_comb
    begin
        logic signed [MW+8:0] share;
        logic signed [MW+9:0] o;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            share = (s31_prod_reg[i] + ((s31_prod_reg[i] < 0) ? 33'sd63 : 33'sd0)) >>> 6;
            o     = (MW+10)'(s31_mix_reg[i]) + (MW+10)'(share);
            if (o < 0)
                s32_o_next[i] = '0;
            else if (o > $signed({{(MW+10-TW){1'b0}}, ONE_Q16}))
                s32_o_next[i] = ONE_Q16;
            else
                s32_o_next[i] = o[TW-1:0];
        end
        if (s31_t_reg < 0)
            thr_next = '0;
        else if (s31_t_reg > 25'sd65535)
            thr_next = 16'hFFFF;
        else
            thr_next = s31_t_reg[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s32_thr_reg <= thr_next;
            for (int i = 0; i < ROW_COUNT; i++)
                s32_o_reg[i] <= s32_o_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 33: map onto DShot 48..2047, apply disarm, output register
    // ------------------------------------------------------------------
    logic [10:0] motor_reg  [ROW_COUNT];
    logic [10:0] motor_next [ROW_COUNT];
    logic [15:0] thr_out_reg;
    logic        out_arm_reg;

    always_comb
    begin
        logic [27:0] scaled;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            scaled = 28'(s32_o_reg[i]) * 28'(DSHOT_STEPS);
            if (arm_dly_reg[ADLY-1] && (i < NMIX))
                motor_next[i] = DSHOT_LOW + 11'(scaled >> 16);
            else
                motor_next[i] = DSHOT_LOW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
                motor_reg[i] <= motor_next[i];
            thr_out_reg <= arm_dly_reg[ADLY-1] ? s32_thr_reg : 16'd0;
            out_arm_reg <= arm_dly_reg[ADLY-1];
        end
    end

    assign motor_0          = motor_reg[0];
    assign motor_1          = motor_reg[1];
    assign motor_2          = motor_reg[2];
    assign motor_3          = motor_reg[3];
    assign throttle_applied = thr_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_disarm_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && !out_arm_reg) |->
        (motor_0 == DSHOT_LOW && motor_1 == DSHOT_LOW && motor_2 == DSHOT_LOW &&
         motor_3 == DSHOT_LOW && throttle_applied == 16'd0))
        else $error("disarmed result carries motor drive");

    a_dshot_floor: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |->
        (motor_0 >= DSHOT_LOW && motor_1 >= DSHOT_LOW && motor_2 >= DSHOT_LOW &&
         motor_3 >= DSHOT_LOW))
        else $error("motor value below DShot floor");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && mix_stall) |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved while result held");

endmodule

FILE: bench/tb_multirotor_motor_mixer.sv
`timescale 1ns / 1ps
// Self-checking bench for multirotor_motor_mixer: random and directed mixer commands,
// predicted in-bench, compared per result. Depends on mmm_pkg and the mixer RTL.

// Expected mixer results, oldest first, with a copy of the register state.
class mixer_scoreboard;
    typedef struct packed {
        logic [10:0] m0, m1, m2, m3;
        logic [15:0] thr;
    } motor_result_t;

    motor_result_t pending[$];
    int            errors;
    logic [11:0]   thr_min;
    logic [11:0]   thr_span;
    logic [31:0]   rows[4];

    function void reset_regs();
        thr_min  = 12'd1000;
        thr_span = 12'd1000;
        rows[0]  = 32'd3225468992;
        rows[1]  = 32'd1086373952;
        rows[2]  = 32'd1077952576;
        rows[3]  = 32'd3233824832;
        errors   = 0;
    endfunction

    function void write_reg(mmm_pkg::cfg_idx_t idx, logic [31:0] data);
        case (idx)
            mmm_pkg::CFG_THR_MIN:  thr_min  = data[11:0];
            mmm_pkg::CFG_THR_SPAN: thr_span = data[11:0];
            mmm_pkg::CFG_ROW0:     rows[0]  = data;
            mmm_pkg::CFG_ROW1:     rows[1]  = data;
            mmm_pkg::CFG_ROW2:     rows[2]  = data;
            mmm_pkg::CFG_ROW3:     rows[3]  = data;
            default: ;
        endcase
    endfunction

    // Coefficient byte k of row r as a signed value.
    function longint cf(int r, int k);
        logic signed [7:0] b;
        b = rows[r][8*k +: 8];
        return longint'(b);
    endfunction

    function void note_command(logic [11:0] cmd, logic signed [12:0] roll,
                               logic signed [12:0] pitch, logic signed [12:0] yaw,
                               logic armed);
        motor_result_t r;
        longint t, sr, sp, sy, lo_m, hi_m, spread, o, span;
        longint mix[4];
        logic [10:0] mo[4];
        if (!armed) begin
            r = '{11'd48, 11'd48, 11'd48, 11'd48, 16'd0};
            pending.push_back(r);
            return;
        end
        span = (thr_span == 0) ? 1 : thr_span;
        if (cmd <= thr_min) t = 0;
        else if (longint'(cmd - thr_min) >= span) t = 65536;
        else t = (longint'(cmd - thr_min) * 65536) / span;
        sr = longint'(roll) * 65536 / 1000;
        sp = longint'(pitch) * 65536 / 1000;
        sy = -(longint'(yaw) * 65536 / 1000);
        for (int i = 0; i < 4; i++)
        begin
            mix[i] = (sr * cf(i, 1) + sp * cf(i, 2) + sy * cf(i, 3)) / 64;
            if (mix[i] > 64'sd2147483647) mix[i] = 64'sd2147483647;
            if (mix[i] < -64'sd2147483648) mix[i] = -64'sd2147483648;
        end
        lo_m = mix[0];
        hi_m = mix[0];
        for (int i = 1; i < 4; i++)
        begin
            if (mix[i] > hi_m) hi_m = mix[i];
            else if (mix[i] < lo_m) lo_m = mix[i];
        end
        spread = hi_m - lo_m;
        if (spread > 65536) begin
            for (int i = 0; i < 4; i++) mix[i] = mix[i] * 65536 / spread;
            lo_m = lo_m * 65536 / spread;
            hi_m = hi_m * 65536 / spread;
        end
        if (t < -lo_m) t = -lo_m;
        else if (t > 65536 - hi_m) t = 65536 - hi_m;
        for (int i = 0; i < 4; i++)
        begin
            o = mix[i] + t * cf(i, 0) / 64;
            if (o < 0) o = 0;
            if (o > 65536) o = 65536;
            mo[i] = 11'(48 + (o * 1999) / 65536);
        end
        r.m0 = mo[0];
        r.m1 = mo[1];
        r.m2 = mo[2];
        r.m3 = mo[3];
        r.thr = (t < 0) ? 16'd0 : (t > 65535) ? 16'hFFFF : 16'(t);
        pending.push_back(r);
    endfunction

    function void check_result(logic [10:0] m0, logic [10:0] m1, logic [10:0] m2,
                               logic [10:0] m3, logic [15:0] thr);
        motor_result_t e;
        if (pending.size() == 0) begin
            $error("result with nothing pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (m0 !== e.m0) begin $error("motor_0 exp %0d got %0d", e.m0, m0); errors++; end
        if (m1 !== e.m1) begin $error("motor_1 exp %0d got %0d", e.m1, m1); errors++; end
        if (m2 !== e.m2) begin $error("motor_2 exp %0d got %0d", e.m2, m2); errors++; end
        if (m3 !== e.m3) begin $error("motor_3 exp %0d got %0d", e.m3, m3); errors++; end
        if (thr !== e.thr) begin
            $error("throttle_applied exp %0d got %0d", e.thr, thr);
            errors++;
        end
    endfunction
endclass

module tb_multirotor_motor_mixer;
    import mmm_pkg::*;

    localparam int LATENCY   = 33;
    localparam int WDOG_MAX  = 5000;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    logic [11:0]        throttle_cmd;
    logic signed [12:0] axis_roll;
    logic signed [12:0] axis_pitch;
    logic signed [12:0] axis_yaw;
    logic               is_armed;
    logic               mix_valid;
    logic               mix_stall;
    logic [10:0]        motor_0;
    logic [10:0]        motor_1;
    logic [10:0]        motor_2;
    logic [10:0]        motor_3;
    logic [15:0]        throttle_applied;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    mixer_scoreboard board;
    int  idle_cycles;
    bit  long_hold;      // request one long receiver hold-off
    bit  stim_done;

    multirotor_motor_mixer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Return a gap length: mostly zero or short, sometimes long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Receiver: random stall, plus one long hold-off on request.
    initial
    begin
        int g;
        mix_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold) begin
                mix_stall = 1'b1;
                repeat (200) @(negedge clk);
                long_hold = 1'b0;
                mix_stall = 1'b0;
            end
            else if (stim_done || $urandom_range(3) == 0) begin
                mix_stall = 1'b0;
            end
            else begin
                g = gap_len();
                mix_stall = (g != 0);
                repeat (g) @(negedge clk);
                mix_stall = 1'b0;
            end
        end
    end

    // Check every accepted result; count cycles without progress.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (mix_valid && !mix_stall)
                board.check_result(motor_0, motor_1, motor_2, motor_3, throttle_applied);
            if ((mix_valid && !mix_stall) || (cmd_valid && !cmd_stall) || cfg_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_MAX) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Drive one command; hold it until accepted.
    task automatic send_cmd(logic [11:0] c, logic [12:0] r, logic [12:0] p,
                            logic [12:0] y, logic a);
        throttle_cmd = c;
        axis_roll    = r;
        axis_pitch   = p;
        axis_yaw     = y;
        is_armed     = a;
        cmd_valid    = 1'b1;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        board.note_command(c, r, p, y, a);
        @(negedge clk);
        cmd_valid = 1'b0;
    endtask

    task automatic send_random(int n);
        int g;
        for (int i = 0; i < n; i++)
        begin
            logic [12:0] r, p, y;
            if ($urandom_range(3) == 0) begin
                r = 13'($urandom);
                p = 13'($urandom);
                y = 13'($urandom);
            end
            else begin
                r = 13'($signed($urandom_range(1200)) - 600);
                p = 13'($signed($urandom_range(1200)) - 600);
                y = 13'($signed($urandom_range(1200)) - 600);
            end
            send_cmd(12'($urandom), r, p, y, $urandom_range(9) != 0);
            g = gap_len();
            repeat (g) @(negedge clk);
        end
    endtask

    // Wait for the pipeline to drain before touching registers.
    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [31:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [11:0] mn, logic [11:0] sp, logic [31:0] r0,
                             logic [31:0] r1, logic [31:0] r2, logic [31:0] r3);
        write_cfg(CFG_THR_MIN, 32'(mn));
        write_cfg(CFG_THR_SPAN, 32'(sp));
        write_cfg(CFG_ROW0, r0);
        write_cfg(CFG_ROW1, r1);
        write_cfg(CFG_ROW2, r2);
        write_cfg(CFG_ROW3, r3);
    endtask

    initial
    begin
        board        = new();
        board.reset_regs();
        idle_cycles  = 0;
        long_hold    = 1'b0;
        stim_done    = 1'b0;
        cmd_valid    = 1'b0;
        throttle_cmd = '0;
        axis_roll    = '0;
        axis_pitch   = '0;
        axis_yaw     = '0;
        is_armed     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_THR_MIN;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: disarmed, throttle bounds, axis extremes, saturation.
        send_cmd(12'd1500, 13'd100, -13'sd100, 13'd50, 1'b0);
        send_cmd(12'd0, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1000, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1001, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1500, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd2000, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd4095, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1500, 13'h0FFF, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1500, 13'h1000, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1500, 13'd0, 13'h0FFF, 13'd0, 1'b1);
        send_cmd(12'd1500, 13'd0, 13'h1000, 13'd0, 1'b1);
        send_cmd(12'd1500, 13'd0, 13'd0, 13'h0FFF, 1'b1);
        send_cmd(12'd1500, 13'd0, 13'd0, 13'h1000, 1'b1);
        send_cmd(12'd4095, 13'h0FFF, 13'h0FFF, 13'h0FFF, 1'b1);
        send_cmd(12'd1200, 13'h1000, 13'h1000, 13'h1000, 1'b1);
        send_cmd(12'd1300, 13'd200, -13'sd150, 13'd300, 1'b1);
        send_random(300);

        // Fill the pipeline behind a long receiver hold-off.
        long_hold = 1'b1;
        send_random(150);
        drain();

        // Span of zero, coefficient extremes.
        write_all(12'd0, 12'd0, 32'h80808080, 32'h7F7F7F7F, 32'h00000000, 32'hFFFFFFFF);
        send_cmd(12'd0, 13'd0, 13'd0, 13'd0, 1'b1);
        send_cmd(12'd1, 13'd10, 13'd10, 13'd10, 1'b1);
        send_random(250);
        drain();

        write_all(12'd4095, 12'd4095, 32'h7F807F80, 32'h807F807F, 32'h01FF01FF, 32'hFF01FF01);
        send_random(250);
        drain();

        for (int k = 0; k < 4; k++)
        begin
            write_all(12'($urandom), 12'($urandom), $urandom, $urandom, $urandom, $urandom);
            send_random(200);
            drain();
        end

        write_all(12'd1000, 12'd1000, 32'd3225468992, 32'd1086373952,
                  32'd1077952576, 32'd3233824832);
        send_random(150);

        stim_done = 1'b1;
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
src/mmm_pkg.sv
src/mmm_div.sv
src/multirotor_motor_mixer.sv
bench/tb_multirotor_motor_mixer.sv
